@@ design/grc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grc_pkg
// Shared constants, opcodes and the cell control word of the graph
// reachability counter.
// ---------------------------------------------------------------------------
package grc_pkg;

  localparam int MAX_NODES_DEF    = 64;
  localparam int REGION_COUNT_DEF = 16;

  // fixed field widths of the words on the channels
  localparam int FUNC_W   = 2;
  localparam int NODE_W   = 6;
  localparam int REGION_W = 4;
  localparam int COUNT_W  = 7;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD_NODE     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REACH_ALL    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_REACH_REGION = 2'd3;

  // cell operation codes
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_IDLE     = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_NODE = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_EDGE = 3'd2;
  localparam logic [OP_W-1:0] OP_SEED     = 3'd3;
  localparam logic [OP_W-1:0] OP_GROW     = 3'd4;
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd5;
  localparam logic [OP_W-1:0] OP_SHIFT    = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              use_filter;
    logic              seed_reach;
    logic              anchor_vld;
  } grc_ctl_t;

endpackage
`default_nettype wire

@@ design/grc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grc_in_if / grc_out_if
// Valid/ready channels carrying the command word and the result word.
// ---------------------------------------------------------------------------
interface grc_in_if;
  import grc_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [REGION_W-1:0] region;

  modport source (output valid, func, node_a, node_b, region, input ready);
  modport sink   (input valid, func, node_a, node_b, region, output ready);
endinterface

interface grc_out_if;
  import grc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] reach_count;
  logic [COUNT_W-1:0] node_total;
  logic               connected;
  logic               status;

  modport source (output valid, reach_count, node_total, connected, status,
                  input ready);
  modport sink   (input valid, reach_count, node_total, connected, status,
                  output ready);
endinterface
`default_nettype wire

@@ design/grc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grc_cell
// One graph node: presence, region tag, adjacency row and the two visit
// marks (requested traversal and connectivity scan). The traversal mark and the
// miss mark shift toward the chain end during the tally.
// ---------------------------------------------------------------------------
module grc_cell #(
  parameter int MAX_NODES = grc_pkg::MAX_NODES_DEF,
  parameter int RW        = 4,
  parameter int IW        = 6,
  parameter int IDX       = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire grc_pkg::grc_ctl_t    ctl,
  input  wire logic [RW-1:0]        reg_sel,
  input  wire logic [IW-1:0]        anchor,
  input  wire logic [MAX_NODES-1:0] reach_vec,
  input  wire logic [MAX_NODES-1:0] scan_vec,
  input  wire logic                 reach_prev,
  input  wire logic                 miss_prev,
  output logic                      present_o,
  output logic                      reach_o,
  output logic                      scan_o,
  output logic                      miss_o,
  output logic                      grow_o
);
  import grc_pkg::*;

  logic                 present_r, present_nxt;
  logic [RW-1:0]        region_r;
  logic [MAX_NODES-1:0] adj_r, adj_nxt;
  logic                 reach_r, reach_nxt;
  logic                 scan_r, scan_nxt;
  logic                 miss_r, miss_nxt;
  logic                 is_a, is_b, allow_reach, hit_reach, hit_scan;

  assign is_a        = (32'(ctl.node_a) == IDX);
  assign is_b        = (32'(ctl.node_b) == IDX);
  assign allow_reach = present_r && (!ctl.use_filter || region_r == reg_sel);
  assign hit_reach   = |(adj_r & reach_vec);
  assign hit_scan    = |(adj_r & scan_vec);

  always_comb begin
    present_nxt = present_r;
    adj_nxt     = adj_r;
    reach_nxt   = reach_r;
    scan_nxt    = scan_r;
    miss_nxt    = miss_r;
    unique case (ctl.op)
      OP_ADD_NODE: begin
        if (is_a) begin
          present_nxt = 1'b1;
        end
      end
      OP_ADD_EDGE: begin
        for (int j = 0; j < MAX_NODES; j++) begin
          if ((is_a && 32'(ctl.node_b) == j) || (is_b && 32'(ctl.node_a) == j)) begin
            adj_nxt[j] = 1'b1;
          end
        end
      end
      OP_SEED: begin
        reach_nxt = ctl.seed_reach && is_a;
        scan_nxt  = ctl.anchor_vld && (32'(anchor) == IDX);
      end
      OP_GROW: begin
        reach_nxt = reach_r || (allow_reach && hit_reach);
        scan_nxt  = scan_r || (present_r && hit_scan);
      end
      OP_LOAD: begin
        miss_nxt = present_r && !scan_r;
      end
      OP_SHIFT: begin
        // advance marks one cell toward the chain end
        reach_nxt = reach_prev;
        miss_nxt  = miss_prev;
      end
      default: begin
      end
    endcase
  end

  assign grow_o = (!reach_r && allow_reach && hit_reach) ||
                  (!scan_r && present_r && hit_scan);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      adj_r     <= '0;
      reach_r   <= 1'b0;
      scan_r    <= 1'b0;
      miss_r    <= 1'b0;
    end else begin
      present_r <= present_nxt;
      adj_r     <= adj_nxt;
      reach_r   <= reach_nxt;
      scan_r    <= scan_nxt;
      miss_r    <= miss_nxt;
    end
  end

  // region is written once, when the node appears
  always_ff @(posedge clk) begin
    if (ctl.op == OP_ADD_NODE && is_a && !present_r) begin
      region_r <= reg_sel;
    end
  end

  assign present_o = present_r;
  assign reach_o   = reach_r;
  assign scan_o    = scan_r;
  assign miss_o    = miss_r;

endmodule
`default_nettype wire

@@ design/grc_tally.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grc_tally
// Counts reach marks and collects miss marks as they leave the cell chain.
// ---------------------------------------------------------------------------
module grc_tally #(
  parameter int MAX_NODES = grc_pkg::MAX_NODES_DEF,
  parameter int CW        = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr,
  input  wire logic          en,
  input  wire logic          reach_bit,
  input  wire logic          miss_bit,
  output logic [CW-1:0]      count,
  output logic               miss_any
);
  import grc_pkg::*;

  logic [CW-1:0] count_r, count_nxt;
  logic          miss_r, miss_nxt;

  always_comb begin
    count_nxt = count_r;
    miss_nxt  = miss_r;
    if (clr) begin
      count_nxt = '0;
      miss_nxt  = 1'b0;
    end else if (en) begin
      count_nxt = count_r + CW'(reach_bit);
      miss_nxt  = miss_r | miss_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      miss_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      miss_r  <= miss_nxt;
    end
  end

  assign count    = count_r;
  assign miss_any = miss_r;

endmodule
`default_nettype wire

@@ design/graph_reach_counter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// graph_reach_counter
// Undirected graph store with reachability count and connectivity report.
// ---------------------------------------------------------------------------
// Each node lives in one cell of a chain; a cell holds the node's presence,
// region tag, adjacency row and visit marks. One command word is handled at a
// time and gives one result word. Frontier rounds run until both traversals
// stop growing: the requested traversal and the connectivity scan, which
// starts from the first node ever added, grow together one hop per cycle.
// The count is then taken by shifting the reach and miss marks out of the
// chain end, one cell per cycle. The result register holds one word; a new
// command is accepted while it waits, but that command's result is held back
// until the earlier word has left.
// ---------------------------------------------------------------------------
module graph_reach_counter #(
  parameter int MAX_NODES    = grc_pkg::MAX_NODES_DEF,
  parameter int REGION_COUNT = grc_pkg::REGION_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  grc_in_if.sink     in_ch,
  grc_out_if.source  out_ch
);
  import grc_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int RW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] S_EXEC  = 3'd1;
  localparam logic [ST_W-1:0] S_SEED  = 3'd2;
  localparam logic [ST_W-1:0] S_GROW  = 3'd3;
  localparam logic [ST_W-1:0] S_LOAD  = 3'd4;
  localparam logic [ST_W-1:0] S_SHIFT = 3'd5;
  localparam logic [ST_W-1:0] S_DONE  = 3'd6;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [NODE_W-1:0] a_r, b_r;
  logic [RW-1:0]     reg_r, reg_clamp;
  logic              seed_r, seed_nxt;
  logic              status_r, status_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic              anchor_vld_r, anchor_vld_nxt;
  logic [IW-1:0]     anchor_r, anchor_nxt;
  logic [IW-1:0]     sh_cnt_r, sh_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_total_r;
  logic               out_conn_r, out_status_r;
  logic               out_load;

  grc_ctl_t             ctl;
  logic [MAX_NODES-1:0] present_vec, reach_vec, miss_vec, grow_vec, scan_vec;
  logic [MAX_NODES-1:0] reach_prev, miss_prev;
  logic [IW-1:0]        a_idx, b_idx;
  logic                 a_in, b_in, a_ok, b_ok, is_reach;
  logic [CW-1:0]        tally_count;
  logic                 tally_miss;

  assign reg_clamp = (32'(in_ch.region) >= REGION_COUNT) ? RW'(REGION_COUNT - 1)
                                                         : RW'(in_ch.region);

  assign a_idx    = IW'(a_r);
  assign b_idx    = IW'(b_r);
  assign a_in     = (32'(a_r) < MAX_NODES);
  assign b_in     = (32'(b_r) < MAX_NODES);
  assign a_ok     = a_in && present_vec[a_idx];
  assign b_ok     = b_in && present_vec[b_idx];
  assign is_reach = (func_r == FUNC_REACH_ALL) || (func_r == FUNC_REACH_REGION);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // cell control word
  always_comb begin
    ctl.op         = OP_IDLE;
    ctl.node_a     = a_r;
    ctl.node_b     = b_r;
    ctl.use_filter = (func_r == FUNC_REACH_REGION);
    ctl.seed_reach = seed_r;
    ctl.anchor_vld = anchor_vld_r;
    unique case (state_r)
      S_EXEC: begin
        if (func_r == FUNC_ADD_NODE && a_in) begin
          ctl.op = OP_ADD_NODE;
        end else if (func_r == FUNC_ADD_EDGE && a_ok && b_ok) begin
          ctl.op = OP_ADD_EDGE;
        end
      end
      S_SEED:  ctl.op = OP_SEED;
      S_GROW:  ctl.op = OP_GROW;
      S_LOAD:  ctl.op = OP_LOAD;
      S_SHIFT: ctl.op = OP_SHIFT;
      default: ctl.op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    seed_nxt       = seed_r;
    status_nxt     = status_r;
    total_nxt      = total_r;
    anchor_vld_nxt = anchor_vld_r;
    anchor_nxt     = anchor_r;
    sh_cnt_nxt     = sh_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        seed_nxt   = is_reach && a_ok;
        status_nxt = 1'b0;
        unique case (func_r)
          FUNC_ADD_NODE: begin
            if (!a_in) begin
              status_nxt = 1'b1;
            end else if (!present_vec[a_idx]) begin
              total_nxt = total_r + CW'(1);
              if (!anchor_vld_r) begin
                anchor_vld_nxt = 1'b1;
                anchor_nxt     = a_idx;
              end
            end
          end
          FUNC_ADD_EDGE: status_nxt = !(a_ok && b_ok);
          default:       status_nxt = !a_ok;
        endcase
        state_nxt = S_SEED;
      end
      S_SEED: state_nxt = S_GROW;
      S_GROW: begin
        if (!(|grow_vec)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        sh_cnt_nxt = '0;
        state_nxt  = S_SHIFT;
      end
      S_SHIFT: begin
        sh_cnt_nxt = sh_cnt_r + IW'(1);
        if (sh_cnt_r == IW'(MAX_NODES - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seed_r       <= 1'b0;
      status_r     <= 1'b0;
      total_r      <= '0;
      anchor_vld_r <= 1'b0;
      anchor_r     <= '0;
      sh_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seed_r       <= seed_nxt;
      status_r     <= status_nxt;
      total_r      <= total_nxt;
      anchor_vld_r <= anchor_vld_nxt;
      anchor_r     <= anchor_nxt;
      sh_cnt_r     <= sh_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // capture the command word and load the result word
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      a_r    <= in_ch.node_a;
      b_r    <= in_ch.node_b;
      reg_r  <= reg_clamp;
    end
    if (out_load) begin
      out_count_r  <= COUNT_W'(tally_count);
      out_total_r  <= COUNT_W'(total_r);
      out_conn_r   <= anchor_vld_r && !tally_miss;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.reach_count = out_count_r;
  assign out_ch.node_total  = out_total_r;
  assign out_ch.connected   = out_conn_r;
  assign out_ch.status      = out_status_r;

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign reach_prev[i] = 1'b0;
      assign miss_prev[i]  = 1'b0;
    end else begin : g_link
      assign reach_prev[i] = reach_vec[i-1];
      assign miss_prev[i]  = miss_vec[i-1];
    end

    grc_cell #(
      .MAX_NODES(MAX_NODES),
      .RW       (RW),
      .IW       (IW),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .reg_sel   (reg_r),
      .anchor    (anchor_r),
      .reach_vec (reach_vec),
      .scan_vec  (scan_vec),
      .reach_prev(reach_prev[i]),
      .miss_prev (miss_prev[i]),
      .present_o (present_vec[i]),
      .reach_o   (reach_vec[i]),
      .scan_o    (scan_vec[i]),
      .miss_o    (miss_vec[i]),
      .grow_o    (grow_vec[i])
    );
  end

  grc_tally #(
    .MAX_NODES(MAX_NODES),
    .CW       (CW)
  ) u_tally (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (state_r == S_LOAD),
    .en       (state_r == S_SHIFT),
    .reach_bit(reach_vec[MAX_NODES-1]),
    .miss_bit (miss_vec[MAX_NODES-1]),
    .count    (tally_count),
    .miss_any (tally_miss)
  );

endmodule
`default_nettype wire
